// ----- sv/rspc_pkg.sv -----
// Shared types and constants for the range sum pair counter.
package rspc_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register indexes.
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  // Control bits that travel with a word along the cell chain.
  typedef struct packed {
    logic valid;
    logic last;
    logic ovf;
  } item_ctl_t;

endpackage

// ----- sv/range_sum_pair_counter_top.sv -----
// Top level of the range sum pair counter: front end, cell chain and tail.
// A result reaches the out_ ports through the head register, every chain cell and the tail register.
// Throughput: one word per cycle; busy never rises, since the cell chain is fully pipelined.
// Results cannot be stalled: out_valid is a one-cycle strobe and each word leaves in order.
// Reset (rst_n low at a clock edge) clears the running sum, fill level, chain valids and
// range registers; the stored prefixes are left as they are and read only once rewritten.
module range_sum_pair_counter_top #(
  parameter int unsigned MAX_ITEMS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            in_sample,
  input  logic                          in_last,
  output logic                          out_valid,
  output logic [15:0]                   out_pair_total,
  output logic                          out_too_long,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_wdata
);

  // The sum of MAX_ITEMS samples, and any difference of two such prefixes,
  // fits in this many signed bits.
  localparam int unsigned IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W  = rspc_pkg::SAMPLE_W + IDX_W + 1;
  localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(MAX_ITEMS);

  // Range registers, kept across sequences.
  logic signed [31:0]      range_low_r;
  logic signed [31:0]      range_high_r;
  logic signed [SUM_W-1:0] range_low_ext;
  logic signed [SUM_W-1:0] range_high_ext;

  // Front end: running prefix sum and the number of prefixes stored so far.
  logic signed [SUM_W-1:0] running_sum_r;
  logic signed [SUM_W-1:0] running_sum_nxt;
  logic [FILL_W-1:0]       fill_r;
  logic [FILL_W-1:0]       fill_nxt;
  logic signed [SUM_W-1:0] sample_ext;
  logic                    accept;
  logic                    room;

  // Links of the cell chain; link 0 is the front-end output register.
  rspc_pkg::item_ctl_t          link_ctl    [0:MAX_ITEMS];
  logic signed [SUM_W-1:0]      link_prefix [0:MAX_ITEMS];
  logic [IDX_W-1:0]             link_idx    [0:MAX_ITEMS];
  logic [rspc_pkg::COUNT_W-1:0] link_cnt    [0:MAX_ITEMS];

  rspc_pkg::item_ctl_t     head_ctl_r;
  logic signed [SUM_W-1:0] head_prefix_r;
  logic [IDX_W-1:0]        head_idx_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign room   = (fill_r < FILL_LIMIT);

  assign sample_ext     = {{(SUM_W-rspc_pkg::SAMPLE_W){in_sample[31]}}, in_sample};
  assign range_low_ext  = {{(SUM_W-rspc_pkg::SAMPLE_W){range_low_r[31]}}, range_low_r};
  assign range_high_ext = {{(SUM_W-rspc_pkg::SAMPLE_W){range_high_r[31]}}, range_high_r};

  // Configuration writes land directly; the user must write them only while idle, as the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rspc_pkg::REG_RANGE_LOW:  range_low_r  <= cfg_wdata;
        rspc_pkg::REG_RANGE_HIGH: range_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A word past the limit is neither summed nor stored; it travels down the
  // chain only to mark the sequence as too long and, if last, to carry the result.
  assign running_sum_nxt = running_sum_r + sample_ext;
  assign fill_nxt        = fill_r + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= '0;
      fill_r        <= '0;
      head_ctl_r    <= '0;
    end else begin
      head_ctl_r.valid <= accept;
      head_ctl_r.last  <= in_last;
      head_ctl_r.ovf   <= !room;
      if (accept) begin
        if (in_last) begin
          running_sum_r <= '0;
          fill_r        <= '0;
        end else if (room) begin
          running_sum_r <= running_sum_nxt;
          fill_r        <= fill_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    head_prefix_r <= running_sum_nxt;
    head_idx_r    <= fill_r[IDX_W-1:0];
  end

  assign link_ctl[0]    = head_ctl_r;
  assign link_prefix[0] = head_prefix_r;
  assign link_idx[0]    = head_idx_r;
  assign link_cnt[0]    = '0;

  // Cell k keeps the prefix of word k of the current sequence. Every later
  // word of the sequence passes cell k after that write, so a cell is only
  // compared against words whose position lies above its own.
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    rspc_cell #(
      .SUM_W    (SUM_W),
      .IDX_W    (IDX_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .range_low  (range_low_ext),
      .range_high (range_high_ext),
      .ctl_in     (link_ctl[k]),
      .prefix_in  (link_prefix[k]),
      .idx_in     (link_idx[k]),
      .cnt_in     (link_cnt[k]),
      .ctl_out    (link_ctl[k+1]),
      .prefix_out (link_prefix[k+1]),
      .idx_out    (link_idx[k+1]),
      .cnt_out    (link_cnt[k+1])
    );
  end

  // The tail adds each word's own hit, sums the words of a sequence and
  // raises the result strobe when the last word arrives.
  rspc_tail #(
    .SUM_W (SUM_W)
  ) u_tail (
    .clk            (clk),
    .rst_n          (rst_n),
    .range_low      (range_low_ext),
    .range_high     (range_high_ext),
    .ctl_in         (link_ctl[MAX_ITEMS]),
    .prefix_in      (link_prefix[MAX_ITEMS]),
    .cnt_in         (link_cnt[MAX_ITEMS]),
    .out_valid      (out_valid),
    .out_pair_total (out_pair_total),
    .out_too_long   (out_too_long)
  );

`ifndef ASSERT_OFF
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_LIMIT)
    else $error("fill level ran past the prefix capacity");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (fill_r == '0 && running_sum_r == '0))
    else $error("sequence state not cleared after the last word");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(link_ctl[MAX_ITEMS].valid && link_ctl[MAX_ITEMS].last))
    else $error("result strobe without a last word at the chain end");

  a_head_tracks_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> head_ctl_r.valid)
    else $error("accepted word did not enter the chain");
`endif

endmodule

// ----- sv/rspc_cell.sv -----
// One chain cell: holds one stored prefix and counts in-range differences.
module rspc_cell #(
  parameter int unsigned SUM_W    = 41,
  parameter int unsigned IDX_W    = 8,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [SUM_W-1:0]       range_low,
  input  logic signed [SUM_W-1:0]       range_high,
  input  rspc_pkg::item_ctl_t           ctl_in,
  input  logic signed [SUM_W-1:0]       prefix_in,
  input  logic [IDX_W-1:0]              idx_in,
  input  logic [rspc_pkg::COUNT_W-1:0]  cnt_in,
  output rspc_pkg::item_ctl_t           ctl_out,
  output logic signed [SUM_W-1:0]       prefix_out,
  output logic [IDX_W-1:0]              idx_out,
  output logic [rspc_pkg::COUNT_W-1:0]  cnt_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic signed [SUM_W-1:0]      stored_r;
  rspc_pkg::item_ctl_t          ctl_r;
  logic signed [SUM_W-1:0]      prefix_r;
  logic [IDX_W-1:0]             idx_r;
  logic [rspc_pkg::COUNT_W-1:0] cnt_r;
  logic [rspc_pkg::COUNT_W-1:0] cnt_nxt;
  logic signed [SUM_W-1:0]      diff;
  logic                         hit;

  // The stored prefix belongs to an earlier word of this sequence only when
  // this cell sits below the passing word's position.
  assign diff = prefix_in - stored_r;
  assign hit  = ctl_in.valid && !ctl_in.ovf && (MY_IDX < idx_in) &&
                (diff >= range_low) && (diff <= range_high);
  assign cnt_nxt = (hit && (cnt_in != rspc_pkg::COUNT_MAX)) ?
                   cnt_in + rspc_pkg::COUNT_W'(1) : cnt_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    prefix_r <= prefix_in;
    idx_r    <= idx_in;
    cnt_r    <= cnt_nxt;
    if (ctl_in.valid && !ctl_in.ovf && (idx_in == MY_IDX)) begin
      stored_r <= prefix_in;
    end
  end

  assign ctl_out    = ctl_r;
  assign prefix_out = prefix_r;
  assign idx_out    = idx_r;
  assign cnt_out    = cnt_r;

endmodule

// ----- sv/rspc_tail.sv -----
// Chain tail: adds the self hit, accumulates per-sequence totals, drives results.
module rspc_tail #(
  parameter int unsigned SUM_W = 41
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [SUM_W-1:0]       range_low,
  input  logic signed [SUM_W-1:0]       range_high,
  input  rspc_pkg::item_ctl_t           ctl_in,
  input  logic signed [SUM_W-1:0]       prefix_in,
  input  logic [rspc_pkg::COUNT_W-1:0]  cnt_in,
  output logic                          out_valid,
  output logic [rspc_pkg::COUNT_W-1:0]  out_pair_total,
  output logic                          out_too_long
);

  logic [rspc_pkg::COUNT_W-1:0] acc_r;
  logic [rspc_pkg::COUNT_W-1:0] acc_nxt;
  logic                         ovf_r;
  logic                         ovf_nxt;
  logic                         out_valid_r;
  logic [rspc_pkg::COUNT_W-1:0] total_r;
  logic                         too_long_r;
  logic                         self_hit;
  logic [rspc_pkg::COUNT_W-1:0] part;
  logic [rspc_pkg::COUNT_W:0]   sum_wide;

  // A prefix that lies in range by itself is the subarray from the start.
  assign self_hit = !ctl_in.ovf && (prefix_in >= range_low) && (prefix_in <= range_high);
  assign part     = (self_hit && (cnt_in != rspc_pkg::COUNT_MAX)) ?
                    cnt_in + rspc_pkg::COUNT_W'(1) : cnt_in;
  assign sum_wide = {1'b0, acc_r} + {1'b0, part};
  assign acc_nxt  = sum_wide[rspc_pkg::COUNT_W] ? rspc_pkg::COUNT_MAX
                                                 : sum_wide[rspc_pkg::COUNT_W-1:0];
  assign ovf_nxt  = ovf_r | ctl_in.ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_in.valid && ctl_in.last;
      if (ctl_in.valid) begin
        if (ctl_in.last) begin
          acc_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          acc_r <= acc_nxt;
          ovf_r <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r    <= acc_nxt;
    too_long_r <= ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pair_total = total_r;
  assign out_too_long   = too_long_r;

endmodule
